[design/dpf_pkg.sv]
// ----------------------------------------------------------------------------
// dpf_pkg
// Shared widths, prime table, state encoding and the command/status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package dpf_pkg;

    // Field widths and table size
    localparam int VALUE_BITS   = 20;
    localparam int TAG_BITS     = 22;
    localparam int PRIME_COUNT  = 172;
    localparam int PRIME_BITS   = 10;
    localparam int MAX_RESULTS  = 7;

    localparam int IDX_BITS     = (PRIME_COUNT > 1) ? $clog2(PRIME_COUNT) : 1;
    localparam int IDX_CNT_BITS = $clog2(PRIME_COUNT + 1);
    localparam int CNT_BITS     = $clog2(MAX_RESULTS + 1);
    localparam int SQ_BITS      = 2 * PRIME_BITS;
    localparam int CMP_BITS     = (VALUE_BITS > SQ_BITS) ? VALUE_BITS : SQ_BITS;

    // Divider: quotient bits retired per cycle and the resulting cycle count
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_CYCLES    = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int DIV_PAD_BITS  = DIV_CYCLES * DIV_STEP_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_CYCLES + 1);

    typedef logic [PRIME_BITS-1:0] prime_t;
    typedef prime_t prime_tab_t [PRIME_COUNT];

    // All primes below 1024, ascending
    localparam prime_tab_t PRIME_TABLE = '{
        10'd2,    10'd3,    10'd5,    10'd7,    10'd11,   10'd13,   10'd17,   10'd19,
        10'd23,   10'd29,   10'd31,   10'd37,   10'd41,   10'd43,   10'd47,   10'd53,
        10'd59,   10'd61,   10'd67,   10'd71,   10'd73,   10'd79,   10'd83,   10'd89,
        10'd97,   10'd101,  10'd103,  10'd107,  10'd109,  10'd113,  10'd127,  10'd131,
        10'd137,  10'd139,  10'd149,  10'd151,  10'd157,  10'd163,  10'd167,  10'd173,
        10'd179,  10'd181,  10'd191,  10'd193,  10'd197,  10'd199,  10'd211,  10'd223,
        10'd227,  10'd229,  10'd233,  10'd239,  10'd241,  10'd251,  10'd257,  10'd263,
        10'd269,  10'd271,  10'd277,  10'd281,  10'd283,  10'd293,  10'd307,  10'd311,
        10'd313,  10'd317,  10'd331,  10'd337,  10'd347,  10'd349,  10'd353,  10'd359,
        10'd367,  10'd373,  10'd379,  10'd383,  10'd389,  10'd397,  10'd401,  10'd409,
        10'd419,  10'd421,  10'd431,  10'd433,  10'd439,  10'd443,  10'd449,  10'd457,
        10'd461,  10'd463,  10'd467,  10'd479,  10'd487,  10'd491,  10'd499,  10'd503,
        10'd509,  10'd521,  10'd523,  10'd541,  10'd547,  10'd557,  10'd563,  10'd569,
        10'd571,  10'd577,  10'd587,  10'd593,  10'd599,  10'd601,  10'd607,  10'd613,
        10'd617,  10'd619,  10'd631,  10'd641,  10'd643,  10'd647,  10'd653,  10'd659,
        10'd661,  10'd673,  10'd677,  10'd683,  10'd691,  10'd701,  10'd709,  10'd719,
        10'd727,  10'd733,  10'd739,  10'd743,  10'd751,  10'd757,  10'd761,  10'd769,
        10'd773,  10'd787,  10'd797,  10'd809,  10'd811,  10'd821,  10'd823,  10'd827,
        10'd829,  10'd839,  10'd853,  10'd857,  10'd859,  10'd863,  10'd877,  10'd881,
        10'd883,  10'd887,  10'd907,  10'd911,  10'd919,  10'd929,  10'd937,  10'd941,
        10'd947,  10'd953,  10'd967,  10'd971,  10'd977,  10'd983,  10'd991,  10'd997,
        10'd1009, 10'd1013, 10'd1019, 10'd1021
    };

    // Controller states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_FOUND = 6'b001000,
        ST_TAIL  = 6'b010000,
        ST_FLUSH = 6'b100000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic in_ready;    // accept an input word
        logic load;        // capture the input word
        logic div_start;   // divide remainder by current prime
        logic take_quot;   // replace remainder by quotient
        logic next_prime;  // advance to the next table entry
        logic push_prime;  // current prime becomes the pending factor
        logic push_rem;    // remainder becomes the pending factor
        logic push_last;   // send pending factor flagged last
    } dpf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_valid;
        logic in_small;    // input value is zero or one
        logic walk_end;    // table exhausted, prime squared too big, or remainder one
        logic rem_one;
        logic div_done;
        logic div_zero;    // division left no remainder
        logic divided;     // current prime already recorded
        logic out_free;    // output register can take a word this cycle
        logic pend_valid;
        logic cnt_last;    // next pushed factor reaches the result limit
    } dpf_stat_t;

endpackage

[design/dpf_item_if.sv]
// ----------------------------------------------------------------------------
// dpf_item_if
// Input channel: one value to factor with its position tag.
// ----------------------------------------------------------------------------
interface dpf_item_if;
    import dpf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic [TAG_BITS-1:0]   position_tag;

    modport source (output valid, output value, output position_tag, input ready);
    modport sink   (input valid, input value, input position_tag, output ready);
endinterface

[design/dpf_factor_if.sv]
// ----------------------------------------------------------------------------
// dpf_factor_if
// Output channel: one distinct prime factor, its tag and a last flag.
// ----------------------------------------------------------------------------
interface dpf_factor_if;
    import dpf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] prime_factor;
    logic [TAG_BITS-1:0]   tag_out;
    logic                  last_factor;

    modport source (output valid, output prime_factor, output tag_out,
                    output last_factor, input ready);
    modport sink   (input valid, input prime_factor, input tag_out,
                    input last_factor, output ready);
endinterface

[design/dpf_divider.sv]
// ----------------------------------------------------------------------------
// dpf_divider
// Iterative restoring divider of the remainder by a table prime. Retires
// DIV_STEP_BITS quotient bits per cycle; done pulses once results are ready.
// ----------------------------------------------------------------------------
module dpf_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [dpf_pkg::VALUE_BITS-1:0] dividend,
    input  logic [dpf_pkg::PRIME_BITS-1:0] divisor,
    output logic                           done,
    output logic [dpf_pkg::VALUE_BITS-1:0] quotient,
    output logic                           rem_zero
);
    import dpf_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DIV_PAD_BITS-1:0] work_reg, work_next;
    logic [PRIME_BITS-1:0]   part_reg, part_next;
    logic [PRIME_BITS-1:0]   dvs_reg;

    logic [PRIME_BITS-1:0]   step_part;
    logic [DIV_STEP_BITS-1:0] step_q;

    // Run DIV_STEP_BITS restoring steps, MSB of the window first
    always_comb
    begin
        logic [PRIME_BITS:0] trial;
        step_part = part_reg;
        step_q    = '0;
        trial     = '0;
        for (int k = 0; k < DIV_STEP_BITS; k++)
        begin
            trial = {step_part, work_reg[DIV_PAD_BITS-1-k]};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial = trial - {1'b0, dvs_reg};
                step_q[DIV_STEP_BITS-1-k] = 1'b1;
            end
            step_part = trial[PRIME_BITS-1:0];
        end
    end

    // Sequence the iterations
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        part_next = part_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            work_next = DIV_PAD_BITS'(dividend);
            part_next = '0;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[DIV_PAD_BITS-DIV_STEP_BITS-1:0], step_q};
            part_next = step_part;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_BITS'(DIV_CYCLES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        part_reg <= part_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg[VALUE_BITS-1:0];
    assign rem_zero = (part_reg == '0);

endmodule

[design/dpf_datapath.sv]
// ----------------------------------------------------------------------------
// dpf_datapath
// Holds the value, remainder, tag and table index, runs the divider, keeps
// one pending factor so the last flag is known, and drives the output word.
// ----------------------------------------------------------------------------
module dpf_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  dpf_pkg::dpf_cmd_t cmd,
    output dpf_pkg::dpf_stat_t stat,
    dpf_item_if.sink          items,
    dpf_factor_if.source      factors
);
    import dpf_pkg::*;

    logic [VALUE_BITS-1:0]   orig_reg;
    logic [VALUE_BITS-1:0]   rem_reg;
    logic [TAG_BITS-1:0]     tag_reg;
    logic [IDX_CNT_BITS-1:0] idx_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic                    divided_reg;
    logic                    pend_valid_reg;
    logic [VALUE_BITS-1:0]   pend_reg;

    logic                    out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0]   out_factor_reg;
    logic [TAG_BITS-1:0]     out_tag_reg;
    logic                    out_last_reg;

    prime_t                  prime;
    logic [SQ_BITS-1:0]      prime_sq;
    logic                    div_done;
    logic                    div_zero;
    logic [VALUE_BITS-1:0]   div_quot;
    logic                    push;
    logic                    load_out;
    logic [VALUE_BITS-1:0]   pend_new;

    // Look up the current prime and its square
    assign prime    = PRIME_TABLE[idx_reg[IDX_BITS-1:0]];
    assign prime_sq = SQ_BITS'(prime) * SQ_BITS'(prime);

    dpf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rem_reg),
        .divisor  (prime),
        .done     (div_done),
        .quotient (div_quot),
        .rem_zero (div_zero)
    );

    // Pending factor handoff
    assign push     = cmd.push_prime | cmd.push_rem;
    assign load_out = (push & pend_valid_reg) | cmd.push_last;
    assign pend_new = cmd.push_prime ? VALUE_BITS'(prime) : rem_reg;

    // Status back to the controller
    always_comb
    begin
        stat.in_valid   = items.valid;
        stat.in_small   = (items.value <= VALUE_BITS'(1));
        stat.rem_one    = (rem_reg == VALUE_BITS'(1));
        stat.walk_end   = (idx_reg == IDX_CNT_BITS'(PRIME_COUNT))
                        || (CMP_BITS'(prime_sq) > CMP_BITS'(orig_reg))
                        || stat.rem_one;
        stat.div_done   = div_done;
        stat.div_zero   = div_zero;
        stat.divided    = divided_reg;
        stat.out_free   = !out_valid_reg || factors.ready;
        stat.pend_valid = pend_valid_reg;
        stat.cnt_last   = (cnt_reg == CNT_BITS'(MAX_RESULTS - 1));
    end

    // Control registers of the walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            cnt_reg        <= '0;
            divided_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg        <= '0;
                cnt_reg        <= '0;
                divided_reg    <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                if (cmd.next_prime)
                begin
                    idx_reg     <= idx_reg + 1'b1;
                    divided_reg <= 1'b0;
                end
                if (push)
                begin
                    cnt_reg        <= cnt_reg + 1'b1;
                    divided_reg    <= 1'b1;
                    pend_valid_reg <= 1'b1;
                end
                if (cmd.push_last)
                begin
                    pend_valid_reg <= 1'b0;
                end
            end
        end
    end

    // Value, remainder, tag and pending factor
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            orig_reg <= items.value;
            rem_reg  <= items.value;
            tag_reg  <= items.position_tag;
        end
        else if (cmd.take_quot)
        begin
            rem_reg <= div_quot;
        end
        if (push)
        begin
            pend_reg <= pend_new;
        end
    end

    // Output register: load a word, drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (factors.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_factor_reg <= pend_reg;
            out_tag_reg    <= tag_reg;
            out_last_reg   <= cmd.push_last;
        end
    end

    assign items.ready          = cmd.in_ready;
    assign factors.valid        = out_valid_reg;
    assign factors.prime_factor = out_factor_reg;
    assign factors.tag_out      = out_tag_reg;
    assign factors.last_factor  = out_last_reg;

endmodule

[design/dpf_ctrl.sv]
// ----------------------------------------------------------------------------
// dpf_ctrl
// Controller that walks the prime table: check bounds, divide, record
// factors, emit the leftover remainder and flush the last word.
// ----------------------------------------------------------------------------
module dpf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  dpf_pkg::dpf_stat_t stat,
    output dpf_pkg::dpf_cmd_t  cmd
);
    import dpf_pkg::*;

    state_t state_reg, state_next;
    logic   can_push;

    // A new pending factor may replace the old one only if its word can leave
    assign can_push = stat.out_free || !stat.pend_valid;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    cmd.load = 1'b1;
                    if (!stat.in_small)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (stat.walk_end)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    if (stat.div_zero)
                    begin
                        cmd.take_quot = 1'b1;
                        state_next    = stat.divided ? ST_CHECK : ST_FOUND;
                    end
                    else
                    begin
                        cmd.next_prime = 1'b1;
                        state_next     = ST_CHECK;
                    end
                end
            end
            ST_FOUND:
            begin
                if (can_push)
                begin
                    cmd.push_prime = 1'b1;
                    state_next     = stat.cnt_last ? ST_FLUSH : ST_CHECK;
                end
            end
            ST_TAIL:
            begin
                if (stat.rem_one)
                begin
                    state_next = ST_FLUSH;
                end
                else if (can_push)
                begin
                    cmd.push_rem = 1'b1;
                    state_next   = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!stat.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.push_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[design/distinct_prime_factor_extractor.sv]
// ----------------------------------------------------------------------------
// distinct_prime_factor_extractor
// Trial-division factorizer: emits the distinct prime factors of a value in
// ascending order, each with the caller's tag and a last-of-run flag.
// ----------------------------------------------------------------------------
// One value is worked on at a time; the input takes a word only while the
// block is idle. A value of zero or one is taken and gives no words.
// Otherwise the controller walks the 172-entry prime table while the
// prime squared does not exceed the value and the remainder is above one.
// Each prime tried goes through a check and one division by the shared
// divider, which retires 4 quotient bits per cycle; a dividing prime is
// divided again until it no longer divides, and a found factor passes
// through a recording state. After the walk the leftover remainder is
// emitted and the last pending word is flushed. A pending factor register
// and an output register hold words, so output stalls delay the walk only
// when a factor must move into the output register while the word ahead of
// it is still waiting there.
// ----------------------------------------------------------------------------
module distinct_prime_factor_extractor (
    input  logic         clk,
    input  logic         rst_n,
    dpf_item_if.sink     items,
    dpf_factor_if.source factors
);
    import dpf_pkg::*;

    dpf_cmd_t  cmd;
    dpf_stat_t stat;

    dpf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    dpf_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .items   (items),
        .factors (factors)
    );

endmodule

[dv/tb_distinct_prime_factor_extractor.sv]
// ----------------------------------------------------------------------------
// tb_distinct_prime_factor_extractor
// Self-checking bench for the trial-division factorizer. A queue of values and
// tags is filled up front: first the corner values, then random ones biased
// toward smooth numbers, semiprimes near the table end and small values. A
// burst driver offers each word, and a scoreboard predicts the ascending run
// of distinct prime factors for every accepted word. The factor port is
// checked word by word while ready stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_distinct_prime_factor_extractor;
    import dpf_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int RANDOM_JOBS   = 250;
    localparam int DRAIN_CYCLES  = 1500;
    localparam int TIMEOUT_TICKS = 20_000_000;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
    localparam logic [TAG_BITS-1:0]   TAG_MAX   = '1;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [TAG_BITS-1:0]   tag;
    } factor_job_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] prime_factor;
        logic [TAG_BITS-1:0]   tag;
        logic                  last_factor;
    } factor_word_t;

    logic clk;
    logic rst_n;

    dpf_item_if   item_ch ();
    dpf_factor_if factor_ch ();

    distinct_prime_factor_extractor dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .factors (factor_ch)
    );

    // Bench copy of the prime table, built by trial division
    int unsigned  trial_primes [PRIME_COUNT];
    factor_job_t  factor_jobs [$];
    factor_word_t expected_factors [$];
    int           accepted_jobs;
    int           error_count = 0;

    // Driver bookkeeping
    int           offered_index;
    int           burst_left;
    int           gap_left;

    // Receiver stall bookkeeping
    int           stall_left;
    int           run_left;

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    // Expand one value into its run of distinct prime factors
    task automatic predict_factors(input logic [VALUE_BITS-1:0] value,
                                   input logic [TAG_BITS-1:0]   tag);
        int unsigned  orig;
        int unsigned  rest;
        int unsigned  p;
        int unsigned  found [MAX_RESULTS];
        int           n;
        factor_word_t w;
        orig = value;
        rest = orig;
        n    = 0;
        if (orig <= 1)
            return;
        for (int i = 0; i < PRIME_COUNT; i++)
        begin
            p = trial_primes[i];
            if (p * p > orig || rest == 1)
                break;
            if (rest % p != 0)
                continue;
            if (n < MAX_RESULTS)
            begin
                found[n] = p;
                n++;
            end
            while (rest % p == 0)
                rest = rest / p;
        end
        // leftover remainder is the final factor
        if (rest != 1 && n < MAX_RESULTS)
        begin
            found[n] = rest;
            n++;
        end
        for (int k = 0; k < n; k++)
        begin
            w.prime_factor = found[k][VALUE_BITS-1:0];
            w.tag          = tag;
            w.last_factor  = (k == n - 1);
            expected_factors = {expected_factors, w};
        end
    endtask

    // Random value drawn from a mix of shapes
    function automatic logic [VALUE_BITS-1:0] random_value();
        int unsigned v;
        int unsigned p;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        v    = 1;
        case (kind)
            0, 1, 2:
                v = $urandom_range(0, VALUE_MAX);
            3, 4, 5:
            begin
                // smooth number: mostly small primes, some repeated
                repeat ($urandom_range(1, 12))
                begin
                    p = trial_primes[$urandom_range(0, ($urandom_range(0, 3) == 0) ? 60 : 10)];
                    if (v * p <= VALUE_MAX)
                        v = v * p;
                end
            end
            6:
                v = $urandom_range(0, 2000);
            7:
                // semiprime from the top of the table
                v = trial_primes[$urandom_range(100, PRIME_COUNT - 1)]
                    * trial_primes[$urandom_range(100, PRIME_COUNT - 1)];
            default:
            begin
                // small prime times a large random cofactor
                p = trial_primes[$urandom_range(0, 5)];
                v = p * $urandom_range(1, VALUE_MAX / p);
            end
        endcase
        return v[VALUE_BITS-1:0];
    endfunction

    function automatic logic [TAG_BITS-1:0] random_tag();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return TAG_MAX;
            default: return $urandom_range(0, TAG_MAX);
        endcase
    endfunction

    task automatic add_job(input int unsigned value, input logic [TAG_BITS-1:0] tag);
        factor_job_t j;
        j.value = value[VALUE_BITS-1:0];
        j.tag   = tag;
        factor_jobs = {factor_jobs, j};
    endtask

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
            #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #TIMEOUT_TICKS;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned cand;
        int          count;
        bit          is_prime;

        rst_n = 1'b0;

        // build the prime table
        cand  = 2;
        count = 0;
        while (count < PRIME_COUNT)
        begin
            is_prime = 1'b1;
            for (int j = 0; j < count; j++)
            begin
                if (trial_primes[j] * trial_primes[j] > cand)
                    break;
                if (cand % trial_primes[j] == 0)
                begin
                    is_prime = 1'b0;
                    break;
                end
            end
            if (is_prime)
            begin
                trial_primes[count] = cand;
                count++;
            end
            cand++;
        end

        // directed corners: zero and one give nothing, smallest primes,
        // squares at the walk boundary, seven distinct factors, field maxima
        add_job(0, '0);
        add_job(1, TAG_MAX);
        add_job(2, 22'h15_5555);
        add_job(3, 22'h2A_AAAA);
        add_job(4, 1);
        add_job(25, 2);
        add_job(49, 3);
        add_job(510510, 4);           // 2*3*5*7*11*13*17
        add_job(524288, 5);           // 2^19
        add_job(531441, 6);           // 3^12
        add_job(VALUE_MAX, 7);        // 3*5^2*11*31*41
        add_job(1048573, TAG_MAX);    // largest 20-bit prime
        add_job(1048574, '0);         // 2 * large prime
        add_job(1042441, 8);          // largest table prime squared
        add_job(1040399, 9);          // 1019*1021
        add_job(1044403, 10);         // 1013 * prime beyond the table
        add_job(1021, 11);
        add_job(1031, 12);
        add_job(1, 13);
        add_job(0, TAG_MAX);
        add_job(6, 14);
        add_job(1024, 15);

        repeat (RANDOM_JOBS)
            add_job(random_value(), random_tag());

        // hold reset, release on a falling edge
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait for all words to go in and all factors to come out
        while (accepted_jobs < factor_jobs.size() || expected_factors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input driver: bursts of words with random gaps
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic        next_valid;
        factor_job_t next_job;
        next_valid = 1'b0;
        next_job   = '{value: item_ch.value, tag: item_ch.position_tag};
        if (!rst_n)
        begin
            burst_left    = $urandom_range(1, 8);
            gap_left      = 0;
            offered_index = -1;
            next_job      = '0;
        end
        else if (item_ch.valid && accepted_jobs == offered_index)
        begin
            // hold the word until taken
            next_valid = 1'b1;
        end
        else if (gap_left > 0)
        begin
            gap_left--;
        end
        else if (accepted_jobs < factor_jobs.size())
        begin
            next_valid    = 1'b1;
            next_job      = factor_jobs[accepted_jobs];
            offered_index = accepted_jobs;
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 8);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            end
        end
        item_ch.valid        <= next_valid;
        item_ch.value        <= next_job.value;
        item_ch.position_tag <= next_job.tag;
    end

    // ------------------------------------------------------------------------
    // Output ready: free-running stretches broken by stalls
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic next_ready;
        next_ready = 1'b1;
        if (!rst_n)
        begin
            stall_left = 0;
            run_left   = 20;
            next_ready = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            next_ready = 1'b0;
        end
        else if (run_left > 0)
        begin
            run_left--;
        end
        else
        begin
            // start a stall, then pick a long or a short run
            stall_left = $urandom_range(0, 11);
            next_ready = 1'b0;
            run_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 400)
                                                     : $urandom_range(0, 4);
        end
        factor_ch.ready <= next_ready;
    end

    // ------------------------------------------------------------------------
    // Scoreboard: check factor words, then predict from accepted inputs
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        factor_word_t want;
        if (!rst_n)
        begin
            accepted_jobs <= 0;
        end
        else
        begin
            if (factor_ch.valid && factor_ch.ready)
            begin
                if (expected_factors.size() == 0)
                    report_mismatch($sformatf("unexpected factor %0d tag %0d",
                                              factor_ch.prime_factor, factor_ch.tag_out));
                else
                begin
                    want = expected_factors.pop_front();
                    if (factor_ch.prime_factor !== want.prime_factor)
                        report_mismatch($sformatf("prime_factor %0d, want %0d (tag %0d)",
                                                  factor_ch.prime_factor, want.prime_factor,
                                                  want.tag));
                    if (factor_ch.tag_out !== want.tag)
                        report_mismatch($sformatf("tag_out %0d, want %0d",
                                                  factor_ch.tag_out, want.tag));
                    if (factor_ch.last_factor !== want.last_factor)
                        report_mismatch($sformatf("last_factor %0b, want %0b (factor %0d)",
                                                  factor_ch.last_factor, want.last_factor,
                                                  want.prime_factor));
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                predict_factors(item_ch.value, item_ch.position_tag);
                accepted_jobs <= accepted_jobs + 1;
            end
        end
    end

endmodule

[distinct_prime_factor_extractor.f]
design/dpf_pkg.sv
design/dpf_item_if.sv
design/dpf_factor_if.sv
design/dpf_divider.sv
design/dpf_datapath.sv
design/dpf_ctrl.sv
design/distinct_prime_factor_extractor.sv
dv/tb_distinct_prime_factor_extractor.sv
